@@ hdl/bq_pkg.sv @@
// ----------------------------------------------------------------------------
// Biquad filter package
// Widths, coefficient bank type, register indexes and control structs shared
// by the biquad section and its serial multipliers.
// ----------------------------------------------------------------------------
`default_nettype none

package bq_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int STATE_W   = 40;
  localparam int COEF_FRAC = COEF_W - 3;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  // Three-term sums of state and products are formed without loss.
  localparam int SUM_W     = ((STATE_W > PROD_W) ? STATE_W : PROD_W) + 2;
  // Width of the output sum after the fraction bits are dropped.
  localparam int Y_W       = SUM_W - COEF_FRAC;
  localparam int CNT_W     = $clog2(SAMPLE_W);
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_W - 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [STATE_W-1:0]  state_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  localparam coef_t COEF_ONE = {2'b00, 1'b1, {COEF_FRAC{1'b0}}};
  localparam sum_t  ROUND_HALF = {{(SUM_W - COEF_FRAC){1'b0}}, 1'b1,
                                  {(COEF_FRAC - 1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF0 = 3'd0,
    REG_FF1 = 3'd1,
    REG_FB1 = 3'd2,
    REG_FF2 = 3'd3,
    REG_FB2 = 3'd4
  } reg_idx_t;

  typedef struct packed {
    coef_t ff0;
    coef_t ff1;
    coef_t fb1;
    coef_t ff2;
    coef_t fb2;
  } coef_bank_t;

  typedef struct packed {
    logic load;
    logic step;
  } mul_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/biquad_iir_filter.sv @@
// ----------------------------------------------------------------------------
// Biquad IIR filter
// Second-order section in transposed direct form II with serial multipliers.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, sample_in) takes one signed sample
//   per transfer; the output channel (out_valid, out_ready, sample_out,
//   saturated) returns one filtered sample per input, in order.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
//   writes the five coefficients; it is always ready and must only be used
//   while no sample is in flight. Unknown indexes are ignored.
//   An accepted sample runs through three shift-add multipliers for the
//   feedforward products, then one step rounds and clips the output, a
//   second pass over the sample bits forms the two feedback products, and
//   one step updates the state. The result appears as the section returns
//   to idle, and the next sample can be taken from then on; the sample rate
//   is set by the bit-serial multiply over the sample width, done twice.
//   A finished result waits in the output register; a new sample is still
//   accepted, and the state update stalls only if the previous result has
//   not been taken by then.
//   Synchronous reset clears both state registers, sets coefficient 0 to one
//   and the others to zero, and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_iir_filter (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [bq_pkg::SAMPLE_W-1:0]      sample_in,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [bq_pkg::SAMPLE_W-1:0]      sample_out,
  output logic                             saturated,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [bq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [bq_pkg::COEF_W-1:0]        cfg_data
);
  import bq_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MULX  = 5'b00010,
    ST_YCALC = 5'b00100,
    ST_MULY  = 5'b01000,
    ST_UPD   = 5'b10000
  } state_e_t;

  state_e_t          state, state_next;
  logic [CNT_W-1:0]  cnt;
  coef_bank_t        coefs;
  mul_ctrl_t         ctrl0, ctrl12;
  sample_t           operand12;
  coef_t             coef1, coef2;
  prod_t             prod0, prod1, prod2;
  prod_t             p1, p2;
  state_t            d1, d2;
  sample_t           y;
  logic              clip_y;
  logic              in_xfer, out_free, upd_fire;

  sum_t              y_sum;
  logic [Y_W-1:0]    y_sh;
  logic              y_ovf;
  sample_t           y_sat;
  sum_t              d1_sum, d2_sum;
  logic              d1_ovf, d2_ovf;
  state_t            d1_sat, d2_sat;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign upd_fire  = (state == ST_UPD) && out_free;

  bq_coef_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  // Unit 0 forms x*ff0; units 1 and 2 form x*ff1 and x*ff2, then y*fb1 and
  // y*fb2 in the second pass.
  assign ctrl0.load  = in_xfer;
  assign ctrl0.step  = (state == ST_MULX);
  assign ctrl12.load = in_xfer || (state == ST_YCALC);
  assign ctrl12.step = (state == ST_MULX) || (state == ST_MULY);
  assign operand12   = (state == ST_YCALC) ? y_sat : sample_t'(sample_in);
  assign coef1       = (state == ST_MULY) ? coefs.fb1 : coefs.ff1;
  assign coef2       = (state == ST_MULY) ? coefs.fb2 : coefs.ff2;

  bq_smul u_mul0 (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl0),
    .operand (sample_t'(sample_in)),
    .coef    (coefs.ff0),
    .product (prod0)
  );

  bq_smul u_mul1 (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl12),
    .operand (operand12),
    .coef    (coef1),
    .product (prod1)
  );

  bq_smul u_mul2 (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl12),
    .operand (operand12),
    .coef    (coef2),
    .product (prod2)
  );

  // Output: round half up, drop the fraction bits, clip to the sample range.
  always_comb begin
    y_sum = SUM_W'(d1) + SUM_W'(prod0) + ROUND_HALF;
    y_sh  = y_sum[SUM_W-1:COEF_FRAC];
    y_ovf = !((&y_sh[Y_W-1:SAMPLE_W-1]) || !(|y_sh[Y_W-1:SAMPLE_W-1]));
    if (y_ovf) begin
      y_sat = y_sh[Y_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      y_sat = y_sh[SAMPLE_W-1:0];
    end
  end

  // State update, each sum clipped to the state range.
  always_comb begin
    d1_sum = SUM_W'(d2) + SUM_W'(p1) + SUM_W'(prod1);
    d2_sum = SUM_W'(p2) + SUM_W'(prod2);
    d1_ovf = !((&d1_sum[SUM_W-1:STATE_W-1]) || !(|d1_sum[SUM_W-1:STATE_W-1]));
    d2_ovf = !((&d2_sum[SUM_W-1:STATE_W-1]) || !(|d2_sum[SUM_W-1:STATE_W-1]));
    if (d1_ovf) begin
      d1_sat = d1_sum[SUM_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
    end else begin
      d1_sat = d1_sum[STATE_W-1:0];
    end
    if (d2_ovf) begin
      d2_sat = d2_sum[SUM_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
    end else begin
      d2_sat = d2_sum[STATE_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_xfer) state_next = ST_MULX;
      ST_MULX:  if (cnt == CNT_LAST) state_next = ST_YCALC;
      ST_YCALC: state_next = ST_MULY;
      ST_MULY:  if (cnt == CNT_LAST) state_next = ST_UPD;
      ST_UPD:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      d1        <= '0;
      d2        <= '0;
    end else begin
      state <= state_next;
      if ((state == ST_MULX) || (state == ST_MULY)) begin
        cnt <= (cnt == CNT_LAST) ? '0 : cnt + 1'b1;
      end
      if (upd_fire) begin
        out_valid <= 1'b1;
        d1        <= d1_sat;
        d2        <= d2_sat;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_YCALC) begin
      p1     <= prod1;
      p2     <= prod2;
      y      <= y_sat;
      clip_y <= y_ovf;
    end
    if (upd_fire) begin
      sample_out <= y;
      saturated  <= clip_y || d1_ovf || d2_ovf;
    end
  end

  // A transfer starts the first multiply pass from a cleared counter.
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == ST_MULX) && (cnt == '0))
    else $error("multiply pass did not start after input transfer");

  // The output is formed only after a full pass over the sample bits.
  a_full_pass: assert property (@(posedge clk) disable iff (rst)
    (state == ST_YCALC) |-> ($past(state) == ST_MULX) && ($past(cnt) == CNT_LAST))
    else $error("output formed before the multiply pass finished");

  // The feedback pass follows the output step directly.
  a_fb_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MULY) && ($past(state) != ST_MULY) |-> ($past(state) == ST_YCALC))
    else $error("feedback pass entered out of order");

  // A state update always delivers a result and frees the input.
  a_update: assert property (@(posedge clk) disable iff (rst)
    upd_fire |=> out_valid && (state == ST_IDLE))
    else $error("state update did not present a result");

  // No new sample is taken while the section is busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready)
    else $error("input ready while busy");

endmodule

`default_nettype wire

@@ hdl/bq_coef_regs.sv @@
// ----------------------------------------------------------------------------
// Biquad coefficient registers
// Holds the five Q3.15 coefficients written through the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module bq_coef_regs (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_valid,
  input  wire  [bq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [bq_pkg::COEF_W-1:0]          cfg_data,
  output bq_pkg::coef_bank_t                 coefs
);
  import bq_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.ff0 <= COEF_ONE;
      coefs.ff1 <= '0;
      coefs.fb1 <= '0;
      coefs.ff2 <= '0;
      coefs.fb2 <= '0;
    end else if (cfg_valid) begin
      // Writes to indexes past the last register are dropped.
      unique case (reg_idx_t'(cfg_index))
        REG_FF0: coefs.ff0 <= coef_t'(cfg_data);
        REG_FF1: coefs.ff1 <= coef_t'(cfg_data);
        REG_FB1: coefs.fb1 <= coef_t'(cfg_data);
        REG_FF2: coefs.ff2 <= coef_t'(cfg_data);
        REG_FB2: coefs.fb2 <= coef_t'(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/bq_smul.sv @@
// ----------------------------------------------------------------------------
// Biquad serial multiplier
// Signed sample by coefficient product, one sample bit per step, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module bq_smul (
  input  wire                   clk,
  input  wire                   rst,
  input  bq_pkg::mul_ctrl_t     ctrl,
  input  bq_pkg::sample_t       operand,
  input  bq_pkg::coef_t         coef,
  output bq_pkg::prod_t         product
);
  import bq_pkg::*;

  logic [SAMPLE_W-1:0] opnd_sr;
  logic                first;
  prod_t               acc;
  prod_t               coef_ext;
  prod_t               addend;

  assign coef_ext = PROD_W'(coef);

  // The sign bit of the sample comes first and carries negative weight.
  always_comb begin
    if (opnd_sr[SAMPLE_W-1]) begin
      addend = first ? -coef_ext : coef_ext;
    end else begin
      addend = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b0;
    end else if (ctrl.load) begin
      first <= 1'b1;
    end else if (ctrl.step) begin
      first <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      opnd_sr <= operand;
      acc     <= '0;
    end else if (ctrl.step) begin
      opnd_sr <= {opnd_sr[SAMPLE_W-2:0], 1'b0};
      acc     <= (acc <<< 1) + addend;
    end
  end

  assign product = acc;

endmodule

`default_nettype wire
